@@ hw/rtl/dstk_pkg.sv @@
// ----------------------------------------------------------------------------
// dstk_pkg
// shared widths, operation codes and status codes of the double ended stack
// ----------------------------------------------------------------------------
`default_nettype none

package dstk_pkg;

   localparam int DEPTH_DEF = 128;
   localparam int WORD_W    = 32;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 8;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_PUSH_TOP    = 2'd0;
   localparam kind_type KIND_PUSH_BOTTOM = 2'd1;
   localparam kind_type KIND_POP_TOP     = 2'd2;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_OVERFLOW  = 2'd1;
   localparam status_type STATUS_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/double_ended_stack_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_stack_core
// bounded ring store of 32-bit words: push on top, push at bottom, pop top
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_stall) carries one transaction: req_kind selects
//   push on top, push at bottom or pop from top; req_value is the pushed word.
//   rsp channel (rsp_valid/rsp_stall) returns exactly one transaction per
//   request with rsp_status, rsp_popped and rsp_fill (count after the request).
//   rsp_valid rises in the cycle after request acceptance. throughput is one
//   transaction per cycle unless rsp_stall holds a response: each request is
//   at most one access to the word memory (one write for a push, one registered
//   read for a pop), and the top and bottom pointers are updated at acceptance.
//   a full store refuses a push with overflow; an empty store answers a pop
//   with underflow and the word -1. unused kind codes answer ok and change
//   nothing.
//   reset empties the store at once (pointers and count cleared, no sweep).
//   while rsp_stall holds a pending response, req_stall is raised and the
//   response and its registered read data are held unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_stack_core
   import dstk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic signed [WORD_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [WORD_W-1:0]      rsp_popped,
   output logic [FILL_W-1:0]             rsp_fill
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [AW-1:0]       bottom_ff, bottom_in;
   logic [AW-1:0]       top_ff, top_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic                pop_ok_ff, pop_ok_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [WORD_W-1:0]   rd_data_ff;

   logic                accept;
   logic                full, empty;
   logic [AW-1:0]       top_dec, top_inc, bottom_dec;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr;
   logic [FILL_W+CW-1:0] fill_ext;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign top_dec    = ptr_dec(top_ff);
   assign top_inc    = ptr_inc(top_ff);
   assign bottom_dec = ptr_dec(bottom_ff);

   always_comb begin
      bottom_in    = bottom_ff;
      top_in       = top_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pop_ok_in    = pop_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = top_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         pop_ok_in    = 1'b0;
         unique case (req_kind)
            KIND_PUSH_TOP: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = top_ff;
                  top_in   = top_inc;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_PUSH_BOTTOM: begin
               if (full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = bottom_dec;
                  bottom_in = bottom_dec;
                  count_in  = count_ff + CW'(1);
               end
            end
            KIND_POP_TOP: begin
               if (empty) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  rd_en     = 1'b1;
                  pop_ok_in = 1'b1;
                  top_in    = top_dec;
                  count_in  = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   assign fill_ext = {{FILL_W{1'b0}}, count_in};
   assign fill_in  = accept ? fill_ext[FILL_W-1:0] : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff    <= '0;
         top_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bottom_ff    <= bottom_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
      fill_ff   <= fill_in;
   end

   // word memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[top_dec];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_fill   = fill_ff;
   assign rsp_popped = pop_ok_ff ? $signed(rd_data_ff) :
                       (status_ff == STATUS_UNDERFLOW) ? '1 : '0;

   // ring consistency check value: bottom plus count, wrapped once
   logic [CW:0] ring_sum;
   logic [AW-1:0] ring_top;
   assign ring_sum = {{(CW + 1 - AW){1'b0}}, bottom_ff} + {1'b0, count_ff};
   assign ring_top = (ring_sum >= (CW + 1)'(DEPTH)) ?
                     AW'(ring_sum - (CW + 1)'(DEPTH)) : AW'(ring_sum);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("count beyond depth");

   a_ring_top: assert property (@(posedge clock) disable iff (reset)
      top_ff == ring_top)
      else $error("top pointer out of step with bottom and count");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !full && (req_kind == KIND_PUSH_TOP || req_kind == KIND_PUSH_BOTTOM)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted push did not grow count");

   a_overflow_still: assert property (@(posedge clock) disable iff (reset)
      accept && full && (req_kind == KIND_PUSH_TOP || req_kind == KIND_PUSH_BOTTOM)
      |=> count_ff == $past(count_ff) && bottom_ff == $past(bottom_ff))
      else $error("refused push changed state");

   a_underflow_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNDERFLOW |-> rsp_popped == -32'sd1)
      else $error("underflow response without -1");

endmodule

`default_nettype wire
